/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the project.
// Depends on nothing; included by the checker that binds to the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define RSFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define RSFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rsfd_pkg.sv */
// Shared types, constants and helper functions of the serial frame decoder.
// Depends on nothing; imported by every module of the decoder.
package rsfd_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int FRAME_BYTES  = 16;
  localparam int FRAME_SLOTS  = 7;
  localparam int NUM_KNOWN    = 7;

  localparam logic [1:0] CFG_FRAME_GAP    = 2'd0;
  localparam logic [1:0] CFG_SIGNAL_LOSS  = 2'd1;
  localparam logic [1:0] CFG_SNIFF_FRAMES = 2'd2;

  localparam logic [1:0] MODE_UNKNOWN = 2'd0;
  localparam logic [1:0] MODE_TEN     = 2'd1;
  localparam logic [1:0] MODE_ELEVEN  = 2'd2;

  localparam logic [15:0] EMPTY_WORD  = 16'hffff;
  localparam logic [15:0] DROP_MAX    = 16'hffff;
  localparam logic [11:0] VALUE_MID   = 12'd1500;
  localparam logic [11:0] RAW_MID     = 12'd1024;
  // Rounded-up 2^20 / 17, so that (x * RECIP_17) >> 20 == x / 17 for x below 2^14.
  localparam logic [15:0] RECIP_17    = 16'd61681;

  localparam logic [15:0] KNOWN_MASKS [NUM_KNOWN] = '{
    16'h003f, 16'h007f, 16'h00ff, 16'h01ff, 16'h03ff, 16'h1fff, 16'h3fff
  };

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] arrival_time_us;
  } in_item_t;

  typedef struct packed {
    logic        slot_valid;
    logic [3:0]  out_channel;
    logic [11:0] out_value;
    logic [4:0]  channel_count;
    logic        eleven_bit;
    logic [15:0] drop_total;
    logic        last_slot;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_SNIFF,
    ST_VOTE,
    ST_CALC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic frame_chk;
    logic sniff_acc;
    logic vote;
    logic calc;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic mode_known;
    logic slot_last;
    logic out_free;
  } status_t;

  // Number of known channel masks equal to the given mask.
  function automatic logic [2:0] match_count(input logic [15:0] mask);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < NUM_KNOWN; i++) begin
      if (mask == KNOWN_MASKS[i]) begin
        n = n + 3'd1;
      end
    end
    return n;
  endfunction

endpackage

/* rtl/rsfd_ctrl.sv */
// Sequencer of the serial frame decoder: steps byte intake, sniffing and slot output.
// Depends on rsfd_pkg; drives commands into rsfd_dp and reads its status.
module rsfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rsfd_pkg::status_t st,
  output rsfd_pkg::cmd_t    cmd
);
  import rsfd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_byte = in_valid;
        if (in_valid && st.frame_end) begin
          state_nxt = ST_FRAME;
        end
      end
      ST_FRAME: begin
        cmd.frame_chk = 1'b1;
        state_nxt     = st.mode_known ? ST_CALC : ST_SNIFF;
      end
      ST_SNIFF: begin
        cmd.sniff_acc = 1'b1;
        if (st.slot_last) begin
          state_nxt = ST_VOTE;
        end
      end
      ST_VOTE: begin
        cmd.vote  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = st.slot_last ? ST_IDLE : ST_CALC;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rsfd_dp.sv */
// Datapath of the serial frame decoder: frame store, timers, sniffer and slot scaling.
// Depends on rsfd_pkg; commanded by rsfd_ctrl.
module rsfd_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  input  rsfd_pkg::in_item_t in_item,
  input  rsfd_pkg::cmd_t     cmd,
  output rsfd_pkg::status_t  st,
  output logic               out_valid,
  output rsfd_pkg::out_item_t out_item,
  input  logic               out_stall
);
  import rsfd_pkg::*;

  logic [15:0] frame_gap_r;
  logic [31:0] signal_loss_r;
  logic [3:0]  sniff_frames_r;

  logic [15:0] words_r [FRAME_BYTES/2];
  logic [4:0]  byte_cnt_r;
  logic [31:0] last_byte_t_r;
  logic [31:0] last_frame_t_r;
  logic [31:0] frame_t_r;
  logic [1:0]  mode_r;
  logic [15:0] mask_ten_r;
  logic [15:0] mask_eleven_r;
  logic [3:0]  sniff_cnt_r;
  logic [15:0] drop_cnt_r;
  logic [2:0]  slot_r;
  logic [4:0]  count_r;

  logic        c_valid_r;
  logic [3:0]  c_chan_r;
  logic        c_neg_r;
  logic [13:0] c_m10_r;

  logic        out_valid_r;
  out_item_t   out_item_r;

  // Byte intake.
  logic        gap_hit;
  logic [3:0]  wr_idx;
  logic [31:0] byte_gap;
  assign byte_gap = in_item.arrival_time_us - last_byte_t_r;
  assign gap_hit  = (byte_gap > {16'd0, frame_gap_r}) && (byte_cnt_r != 5'd0);
  assign wr_idx   = gap_hit ? 4'd0 : byte_cnt_r[3:0];

  // Frame check.
  logic [31:0] frame_gap;
  logic        loss_hit;
  assign frame_gap = frame_t_r - last_frame_t_r;
  assign loss_hit  = (frame_gap > signal_loss_r) && (mode_r != MODE_UNKNOWN);

  // Slot word for the current slot: bytes 2 + 2 * slot and the one after it.
  logic [2:0]  word_idx;
  logic [15:0] raw;
  assign word_idx = slot_r + 3'd1;
  assign raw      = words_r[word_idx];

  // Slot decode.
  logic        eleven;
  logic [3:0]  chan;
  logic [10:0] v;
  logic [11:0] diff;
  logic [11:0] mag;
  logic [13:0] m10;
  logic        slot_ok;
  logic [4:0]  chan_p1;
  assign eleven  = (mode_r == MODE_ELEVEN);
  assign chan    = eleven ? raw[14:11] : raw[13:10];
  assign v       = eleven ? raw[10:0] : {raw[9:0], 1'b0};
  assign diff    = {1'b0, v} - RAW_MID;
  assign mag     = diff[11] ? (12'd0 - diff) : diff;
  assign m10     = {mag[10:0], 3'b000} + {2'b00, mag[10:0], 1'b0};
  assign slot_ok = (raw != EMPTY_WORD) && ({1'b0, chan} < 5'(MAX_CHANNELS));
  assign chan_p1 = {1'b0, chan} + 5'd1;

  // Scaling: value = 1500 +/- (|v - 1024| * 10) / 17.
  logic [29:0] prod;
  logic [9:0]  quot;
  logic [11:0] value;
  logic [3:0]  chan_map;
  logic [4:0]  count_rep;
  assign prod  = c_m10_r * RECIP_17;
  assign quot  = prod[29:20];
  assign value = c_neg_r ? (VALUE_MID - {2'b00, quot}) : (VALUE_MID + {2'b00, quot});
  always_comb begin
    unique case (c_chan_r)
      4'd0:    chan_map = 4'd2;
      4'd1:    chan_map = 4'd0;
      4'd2:    chan_map = 4'd1;
      default: chan_map = c_chan_r;
    endcase
  end
  assign count_rep = (count_r == 5'd13) ? 5'd12 : count_r;

  // Vote.
  logic [2:0] v10, v11;
  assign v10 = match_count(mask_ten_r);
  assign v11 = match_count(mask_eleven_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_gap_r    <= 16'd5000;
      signal_loss_r  <= 32'd1000000;
      sniff_frames_r <= 4'd5;
      byte_cnt_r     <= 5'd0;
      last_byte_t_r  <= 32'd0;
      last_frame_t_r <= 32'd0;
      mode_r         <= MODE_UNKNOWN;
      mask_ten_r     <= 16'd0;
      mask_eleven_r  <= 16'd0;
      sniff_cnt_r    <= 4'd0;
      drop_cnt_r     <= 16'd0;
      slot_r         <= 3'd0;
      count_r        <= 5'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_FRAME_GAP:    frame_gap_r    <= cfg_wdata[15:0];
          CFG_SIGNAL_LOSS:  signal_loss_r  <= cfg_wdata;
          CFG_SNIFF_FRAMES: sniff_frames_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (cmd.take_byte) begin
        if (gap_hit && drop_cnt_r != DROP_MAX) begin
          drop_cnt_r <= drop_cnt_r + 16'd1;
        end
        byte_cnt_r    <= (wr_idx == 4'd15) ? 5'd0 : {1'b0, wr_idx} + 5'd1;
        last_byte_t_r <= in_item.arrival_time_us;
      end
      if (cmd.frame_chk) begin
        if (loss_hit) begin
          mode_r        <= MODE_UNKNOWN;
          mask_ten_r    <= 16'd0;
          mask_eleven_r <= 16'd0;
          sniff_cnt_r   <= 4'd0;
        end
        last_frame_t_r <= frame_t_r;
        slot_r         <= 3'd0;
        count_r        <= 5'd0;
      end
      if (cmd.sniff_acc) begin
        if (raw != EMPTY_WORD) begin
          mask_ten_r    <= mask_ten_r | (16'd1 << raw[13:10]);
          mask_eleven_r <= mask_eleven_r | (16'd1 << raw[14:11]);
        end
        slot_r <= slot_r + 3'd1;
      end
      if (cmd.vote) begin
        if (sniff_cnt_r < sniff_frames_r) begin
          sniff_cnt_r <= sniff_cnt_r + 4'd1;
        end else if (v11 == 3'd1 && v10 == 3'd0) begin
          mode_r <= MODE_ELEVEN;
        end else if (v10 == 3'd1 && v11 == 3'd0) begin
          mode_r <= MODE_TEN;
        end else begin
          mode_r        <= MODE_UNKNOWN;
          mask_ten_r    <= 16'd0;
          mask_eleven_r <= 16'd0;
          sniff_cnt_r   <= 4'd0;
        end
      end
      if (cmd.calc && slot_ok && chan_p1 > count_r) begin
        count_r <= chan_p1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        slot_r      <= slot_r + 3'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (wr_idx[0]) begin
        words_r[wr_idx[3:1]][7:0] <= in_item.rx_byte;
      end else begin
        words_r[wr_idx[3:1]][15:8] <= in_item.rx_byte;
      end
      frame_t_r <= in_item.arrival_time_us;
    end
    if (cmd.calc) begin
      c_valid_r <= slot_ok;
      c_chan_r  <= chan;
      c_neg_r   <= diff[11];
      c_m10_r   <= m10;
    end
    if (cmd.load_out) begin
      out_item_r.slot_valid    <= c_valid_r;
      out_item_r.out_channel   <= c_valid_r ? chan_map : 4'd0;
      out_item_r.out_value     <= c_valid_r ? value : 12'd0;
      out_item_r.channel_count <= count_rep;
      out_item_r.eleven_bit    <= eleven;
      out_item_r.drop_total    <= drop_cnt_r;
      out_item_r.last_slot     <= (slot_r == 3'(FRAME_SLOTS - 1));
    end
  end

  assign st.frame_end  = (wr_idx == 4'd15);
  assign st.mode_known = !loss_hit && (mode_r != MODE_UNKNOWN);
  assign st.slot_last  = (slot_r == 3'(FRAME_SLOTS - 1));
  assign st.out_free   = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/rc_serial_frame_decoder_core.sv */
// Serial RC frame decoder: one receiver byte per item, seven slot results per frame once the format is known.
// Sequence: a byte is taken while the sequencer is idle; the sixteenth byte of a frame
// leads to a frame check, then either a sniff over the seven slots and a vote, or a
// decode step and an output load for each slot result.
// Throughput: one byte per cycle within a frame; the frame end occupies the sequencer.
// Reset (rst_n, synchronous, active low) restores the register defaults and clears the
// frame counter, timers, format sniffer and drop count; the frame store is not cleared.
// Depends on rsfd_pkg, rsfd_ctrl and rsfd_dp.
module rc_serial_frame_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  input  rsfd_pkg::in_item_t  in_item,
  output logic                in_stall,
  output logic                out_valid,
  output rsfd_pkg::out_item_t out_item,
  input  logic                out_stall
);
  import rsfd_pkg::*;

  // The sequencer accepts bytes only while idle. A completed frame either feeds the
  // format sniffer (one slot per cycle, then a vote) or walks its seven slots, each slot
  // passing a decode step and then a load into the output register, held while out_stall.
  cmd_t    cmd;
  status_t st;

  rsfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the configuration registers, the frame store and the scaler.
  rsfd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule

/* rtl/rsfd_checker.sv */
// Port-level checker for the serial frame decoder core, bound to its top level.
// Depends on rsfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsfd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input rsfd_pkg::out_item_t out_item
);
  import rsfd_pkg::*;

  `RSFD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled item changed")
  `RSFD_ASSERT(a_empty_slot, clk, rst_n, out_valid && !out_item.slot_valid |-> out_item.out_value == 12'd0 && out_item.out_channel == 4'd0, "invalid slot carries data")
  `RSFD_ASSERT(a_value_range, clk, rst_n, out_valid && out_item.slot_valid |-> out_item.out_value >= 12'd898 && out_item.out_value <= 12'd2101, "slot value out of range")
  `RSFD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "item shown after reset")

endmodule

bind rc_serial_frame_decoder_core rsfd_checker u_rsfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
